// File: rtl/mnst_pkg.sv
package mnst_pkg;

    // Geometry and tone constants
    localparam int NOTE_TABLE_DEPTH = 128;
    localparam int NOTE_IDX_W       = $clog2(NOTE_TABLE_DEPTH);
    localparam int PERIOD_W         = 17;
    localparam int PERIOD_FRAC      = 40;
    localparam int RATIO_FRAC       = 62;

    localparam logic [63:0] TONE_NUMERATOR = 64'd312500;
    localparam logic [63:0] BASE_HZ        = 64'd440;
    localparam logic [63:0] RATIO_NUM      = 64'd1059463094;
    localparam logic [63:0] RATIO_DEN      = 64'd1000000000;
    localparam logic [7:0]  NOTE_BIAS      = 8'd81;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    // Status nibbles that open a message (note on, poly aftertouch)
    localparam logic [3:0] STATUS_NOTE_ON    = 4'h9;
    localparam logic [3:0] STATUS_POLY_PRESS = 4'hA;

    // Request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_NOTE   = 2'd1,
        PH_VEL    = 2'd2,
        PH_BAD    = 2'd3
    } parse_phase_t;

    // Gate and note as seen by the tone generator and the result register
    typedef struct packed {
        logic              gate;
        logic signed [7:0] note;
    } note_state_t;

    typedef logic [PERIOD_W-1:0] period_rom_t [NOTE_TABLE_DEPTH];

    // floor(num * 2^frac / den) by restoring long division
    function automatic logic [63:0] fix_div(logic [63:0] num, logic [63:0] den, int frac);
        logic [127:0] dividend;
        logic [64:0]  rem;
        logic [127:0] quo;
        dividend = {64'd0, num} << frac;
        rem = '0;
        quo = '0;
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[63:0], dividend[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo[63:0];
    endfunction

    // floor(a * b / 2^62), low 64 bits kept
    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[RATIO_FRAC+63:RATIO_FRAC];
    endfunction

    function automatic logic [PERIOD_W-1:0] sat_period(logic [63:0] p);
        logic [63-PERIOD_FRAC:0] whole;
        whole = p[63:PERIOD_FRAC];
        if (whole > {{(64-PERIOD_FRAC-PERIOD_W){1'b0}}, PERIOD_MAX}) begin
            return PERIOD_MAX;
        end
        return whole[PERIOD_W-1:0];
    endfunction

    // Half-period table, worked out at elaboration
    function automatic period_rom_t build_rom();
        period_rom_t rom;
        logic [63:0] up;
        logic [63:0] down;
        logic [63:0] base;
        logic [63:0] p;
        up   = fix_div(RATIO_DEN, RATIO_NUM, RATIO_FRAC);
        down = fix_div(RATIO_NUM, RATIO_DEN, RATIO_FRAC);
        base = fix_div(TONE_NUMERATOR, BASE_HZ, PERIOD_FRAC);
        rom[int'(NOTE_BIAS) % NOTE_TABLE_DEPTH] = sat_period(base);
        p = base;
        for (int i = int'(NOTE_BIAS) + 1; i < NOTE_TABLE_DEPTH; i++) begin
            p = mul_q62(p, up);
            rom[i] = sat_period(p);
        end
        p = base;
        for (int i = int'(NOTE_BIAS) - 1; i >= 0; i--) begin
            p = mul_q62(p, down);
            rom[i] = sat_period(p);
        end
        return rom;
    endfunction

    localparam period_rom_t PERIOD_ROM = build_rom();

    // Half period for a note offset from A440
    function automatic logic [PERIOD_W-1:0] note_period(logic signed [7:0] note);
        logic [7:0] idx;
        idx = note + NOTE_BIAS;
        return PERIOD_ROM[idx[NOTE_IDX_W-1:0]];
    endfunction

endpackage

// File: rtl/mnst_parser.sv
module mnst_parser
    import mnst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        upd,
    input  logic        req_type,
    input  logic [7:0]  midi_byte,
    output note_state_t cur,
    output note_state_t nxt
);

    parse_phase_t      phase_reg;
    parse_phase_t      phase_next;
    logic [7:0]        held_reg;
    logic [7:0]        held_next;
    logic              gate_reg;
    logic              gate_next;
    logic signed [7:0] note_reg;
    logic signed [7:0] note_next;
    logic              is_byte;
    logic [3:0]        hi_nib;

    assign is_byte = (req_type == REQ_BYTE);
    assign hi_nib  = midi_byte[7:4];

    // Phase sequencing: status, note, velocity
    always_comb
    begin
        phase_next = phase_reg;
        if (is_byte)
        begin
            case (phase_reg)
                PH_STATUS:
                begin
                    if (hi_nib inside {STATUS_NOTE_ON, STATUS_POLY_PRESS})
                        phase_next = PH_NOTE;
                    else
                        phase_next = PH_STATUS;
                end
                PH_NOTE: phase_next = PH_VEL;
                PH_VEL:  phase_next = PH_STATUS;
                default: phase_next = PH_STATUS;
            endcase
        end
    end

    // Data captured per phase
    always_comb
    begin
        held_next = held_reg;
        gate_next = gate_reg;
        note_next = note_reg;
        if (is_byte)
        begin
            case (phase_reg)
                PH_STATUS: ;
                PH_NOTE:   held_next = midi_byte;
                PH_VEL:
                begin
                    if (midi_byte != 8'd0)
                    begin
                        gate_next = 1'b1;
                        note_next = held_reg - NOTE_BIAS;
                    end
                    else
                    begin
                        gate_next = 1'b0;
                    end
                end
                default: gate_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STATUS;
            held_reg  <= '0;
            gate_reg  <= 1'b0;
            note_reg  <= '0;
        end
        else if (upd)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            gate_reg  <= gate_next;
            note_reg  <= note_next;
        end
    end

    assign cur.gate = gate_reg;
    assign cur.note = note_reg;
    assign nxt.gate = gate_next;
    assign nxt.note = note_next;

endmodule

// File: rtl/mnst_tone.sv
module mnst_tone
    import mnst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        upd,
    input  logic        req_type,
    input  note_state_t cur,
    output logic        level_next
);

    logic [PERIOD_W-1:0] count_reg;
    logic [PERIOD_W-1:0] count_next;
    logic [PERIOD_W-1:0] count_inc;
    logic [PERIOD_W-1:0] period;
    logic                level_reg;

    assign period    = note_period(cur.note);
    assign count_inc = count_reg + 1'b1;

    // Tick: advance, wrap at or above the half period, toggle or force low
    always_comb
    begin
        count_next = count_reg;
        level_next = level_reg;
        if (req_type == REQ_TICK)
        begin
            count_next = count_inc;
            if (count_inc >= period)
            begin
                count_next = '0;
                level_next = cur.gate ? ~level_reg : 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= 1'b0;
        end
        else if (upd)
        begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

// File: rtl/midi_note_square_tone_top.sv
// MIDI note-on square tone generator.
// Input channel (in_valid / in_stall): each request is either a received
// MIDI byte (req_type 0, midi_byte) or one prescaled timer tick (req_type 1).
// Output channel (out_valid / out_stall): exactly one result per request,
// in order: square_out, gate_open, note_offset (signed, from A440) and the
// half period of the current note in ticks.
// Path from request to result: the input register, then the
// parse/count update into the result register.
// Throughput: one request per cycle while the receiver does not stall; the half
// period comes from a 128-entry constant table read in the update stage.
// Reset (rst_n low, asynchronous): parser waits for a status byte, gate
// closed, note A440, tick counter and output level zero, both stages empty.
// When the receiver stalls, the result register holds its value and the
// input register fills; in_stall rises only while both are occupied and
// out_stall is high, so no request is lost or repeated.
module midi_note_square_tone_top
    import mnst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [7:0]            midi_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  square_out,
    output logic                  gate_open,
    output logic signed [7:0]     note_offset,
    output logic [PERIOD_W-1:0]   half_period
);

    logic                s1_valid_reg;
    logic                s1_type_reg;
    logic [7:0]          s1_byte_reg;
    logic                out_valid_reg;
    logic                square_reg;
    logic                gate_reg;
    logic signed [7:0]   note_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                advance;
    logic                upd;
    logic                level_next;
    note_state_t         ps_cur;
    note_state_t         ps_nxt;

    // Pipeline moves when the result register is empty or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign upd      = advance && s1_valid_reg;
    assign in_stall = s1_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_type_reg <= req_type;
            s1_byte_reg <= midi_byte;
        end
    end

    mnst_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .req_type  (s1_type_reg),
        .midi_byte (s1_byte_reg),
        .cur       (ps_cur),
        .nxt       (ps_nxt)
    );

    mnst_tone u_tone (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .req_type   (s1_type_reg),
        .cur        (ps_cur),
        .level_next (level_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            square_reg <= level_next;
            gate_reg   <= ps_nxt.gate;
            note_reg   <= ps_nxt.note;
            period_reg <= note_period(ps_nxt.note);
        end
    end

    assign out_valid   = out_valid_reg;
    assign square_out  = square_reg;
    assign gate_open   = gate_reg;
    assign note_offset = note_reg;
    assign half_period = period_reg;

endmodule

// File: rtl/mnst_checker.sv
module mnst_checker
    import mnst_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                square_out,
    input logic                gate_open,
    input logic signed [7:0]   note_offset,
    input logic [PERIOD_W-1:0] half_period
);

    // Stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(square_out)
            && $stable(gate_open) && $stable(note_offset) && $stable(half_period))
        else $error("result changed while stalled");

    // Stalled request keeps being offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("request withdrawn while stalled");

    // Table entries stay within the note range
    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> half_period >= PERIOD_W'(49) && half_period <= PERIOD_W'(76500))
        else $error("half period out of range");

    // A closed gate never raises a low output
    a_no_rise_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !gate_open && !square_out)
            ##1 (out_valid && !out_stall && !gate_open) |-> !square_out)
        else $error("output rose with gate closed");

    // No stall toward the sender without a pending result to the receiver
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind midi_note_square_tone_top mnst_checker u_mnst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .square_out  (square_out),
    .gate_open   (gate_open),
    .note_offset (note_offset),
    .half_period (half_period)
);
